>>> rtl/core/pept_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pept_pkg;

    localparam int COUNT_WIDTH = 16;

    localparam logic [15:0] PACKET_COUNT_RST  = 16'd4096;
    localparam logic [31:0] START_SEED_RST    = 32'h0000_0000;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

    localparam logic [9:0] PAYLOAD_MASK      = 10'h3FC;
    localparam logic [9:0] PAYLOAD_MIN_BYTES = 10'd64;

    localparam logic [1:0] CFG_PACKET_COUNT  = 2'd0;
    localparam logic [1:0] CFG_START_SEED    = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SEND = 3'd1,
        PH_WAIT = 3'd2,
        PH_RECV = 3'd3,
        PH_OK   = 3'd4,
        PH_ERR  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        CAUSE_NONE    = 3'd0,
        CAUSE_NO_BUF  = 3'd1,
        CAUSE_TIMEOUT = 3'd2,
        CAUSE_SIZE    = 3'd3,
        CAUSE_DATA    = 3'd4
    } cause_t;

    typedef enum logic [1:0] {
        REQ_POLL = 2'd0,
        REQ_PULL = 2'd1,
        REQ_RX   = 2'd2,
        REQ_TICK = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        KIND_POLL = 3'd0,
        KIND_PULL = 3'd1,
        KIND_RX   = 3'd2,
        KIND_TICK = 3'd3,
        KIND_NOP  = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        buf_free;
        logic [31:0] rx_word;
        logic        rx_last;
        logic [10:0] rx_size;
    } item_t;

    // taps 31,6,4,1,0; shift right, feedback into bit 31
    function automatic logic [31:0] lfsr_next(input logic [31:0] s);
        logic fb;
        fb = s[31] ^ s[6] ^ s[4] ^ s[1] ^ s[0];
        return {fb, s[31:1]};
    endfunction

    function automatic logic [9:0] payload_bytes(input logic [9:0] left_low);
        logic [9:0] n;
        n = left_low & PAYLOAD_MASK;
        return (n < PAYLOAD_MIN_BYTES) ? PAYLOAD_MIN_BYTES : n;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/pept_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pept_front
    import pept_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic        s_tx_buffer_free,
    input  wire logic [31:0] s_rx_word,
    input  wire logic        s_rx_last,
    input  wire logic [10:0] s_rx_size_bytes,
    output logic             q_valid,
    input  wire logic        q_ready,
    output item_t            q_item
);

    item_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    item_t       item_in;
    logic        push;
    logic        pop;

    // classify the request
    always_comb begin
        item_in          = '0;
        item_in.buf_free = s_tx_buffer_free;
        item_in.rx_word  = s_rx_word;
        item_in.rx_last  = s_rx_last;
        item_in.rx_size  = s_rx_size_bytes;
        unique case (req_t'(s_req_type))
            REQ_POLL: item_in.kind = KIND_POLL;
            REQ_PULL: item_in.kind = KIND_PULL;
            REQ_RX:   item_in.kind = (s_rx_size_bytes == 11'd0) ? KIND_NOP : KIND_RX;
            REQ_TICK: item_in.kind = KIND_TICK;
            default:  item_in.kind = KIND_NOP;
        endcase
    end

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/pept_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pept_back
    import pept_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        q_valid,
    output logic             q_ready,
    input  wire item_t       q_item,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_phase,
    output logic [2:0]       m_error_cause,
    output logic             m_tx_valid,
    output logic [31:0]      m_tx_word,
    output logic             m_tx_last,
    output logic [9:0]       m_tx_size_bytes
);

    logic [15:0]            timeout_ticks_reg;

    phase_t                 phase_reg, phase_next;
    cause_t                 cause_reg, cause_next;
    logic [COUNT_WIDTH-1:0] packets_left_reg, packets_left_next;
    logic [31:0]            packet_seed_reg, packet_seed_next;
    logic [31:0]            tx_lfsr_reg, tx_lfsr_next;
    logic [7:0]             tx_words_left_reg, tx_words_left_next;
    logic [31:0]            rx_lfsr_reg, rx_lfsr_next;
    logic [7:0]             rx_words_seen_reg, rx_words_seen_next;
    logic [15:0]            wait_timer_reg, wait_timer_next;

    logic                   m_valid_reg;
    logic [2:0]             m_phase_reg;
    logic [2:0]             m_cause_reg;
    logic                   m_tx_valid_reg, m_tx_valid_next;
    logic [31:0]            m_tx_word_reg, m_tx_word_next;
    logic                   m_tx_last_reg, m_tx_last_next;
    logic [9:0]             m_tx_size_reg, m_tx_size_next;

    logic                   go;
    logic                   cfg_go;
    logic [9:0]             pl_bytes;
    logic [7:0]             pl_words;
    logic [7:0]             seen_inc;
    logic [31:0]            rx_lfsr_adv;

    assign cfg_ready   = 1'b1;
    assign cfg_go      = cfg_valid && cfg_ready;
    assign q_ready     = !m_valid_reg || m_ready;
    assign go          = q_valid && q_ready;
    assign pl_bytes    = payload_bytes(packets_left_reg[9:0]);
    assign pl_words    = pl_bytes[9:2];
    assign seen_inc    = rx_words_seen_reg + 8'd1;
    assign rx_lfsr_adv = lfsr_next(rx_lfsr_reg);

    always_comb begin
        phase_next         = phase_reg;
        cause_next         = cause_reg;
        packets_left_next  = packets_left_reg;
        packet_seed_next   = packet_seed_reg;
        tx_lfsr_next       = tx_lfsr_reg;
        tx_words_left_next = tx_words_left_reg;
        rx_lfsr_next       = rx_lfsr_reg;
        rx_words_seen_next = rx_words_seen_reg;
        wait_timer_next    = wait_timer_reg;
        m_tx_valid_next    = 1'b0;
        m_tx_word_next     = 32'd0;
        m_tx_last_next     = 1'b0;
        m_tx_size_next     = 10'd0;
        if (go) begin
            unique case (q_item.kind)
                KIND_POLL: begin
                    if (phase_reg == PH_IDLE || phase_reg == PH_RECV) begin
                        if (packets_left_reg == '0) begin
                            phase_next = PH_OK;
                        end else if (!q_item.buf_free) begin
                            phase_next = PH_ERR;
                            cause_next = CAUSE_NO_BUF;
                        end else begin
                            tx_words_left_next = pl_words;
                            tx_lfsr_next       = packet_seed_reg;
                            phase_next         = PH_SEND;
                        end
                    end
                end
                KIND_PULL: begin
                    if (phase_reg == PH_SEND && tx_words_left_reg != 8'd0) begin
                        m_tx_valid_next    = 1'b1;
                        m_tx_word_next     = tx_lfsr_reg;
                        m_tx_last_next     = (tx_words_left_reg == 8'd1);
                        m_tx_size_next     = pl_bytes;
                        tx_lfsr_next       = lfsr_next(tx_lfsr_reg);
                        tx_words_left_next = tx_words_left_reg - 8'd1;
                        if (tx_words_left_reg == 8'd1) begin
                            phase_next         = PH_WAIT;
                            wait_timer_next    = timeout_ticks_reg;
                            rx_lfsr_next       = packet_seed_reg;
                            rx_words_seen_next = 8'd0;
                        end
                    end
                end
                KIND_RX: begin
                    if (phase_reg == PH_WAIT) begin
                        if (q_item.rx_size != {1'b0, pl_bytes}
                                || rx_words_seen_reg >= pl_words) begin
                            phase_next = PH_ERR;
                            cause_next = CAUSE_SIZE;
                        end else if (q_item.rx_word != rx_lfsr_reg) begin
                            phase_next = PH_ERR;
                            cause_next = CAUSE_DATA;
                        end else begin
                            rx_lfsr_next       = rx_lfsr_adv;
                            rx_words_seen_next = seen_inc;
                            if (q_item.rx_last) begin
                                if (seen_inc != pl_words) begin
                                    phase_next = PH_ERR;
                                    cause_next = CAUSE_SIZE;
                                end else begin
                                    packets_left_next = packets_left_reg - COUNT_WIDTH'(1);
                                    packet_seed_next  = rx_lfsr_adv;
                                    phase_next        = PH_RECV;
                                end
                            end
                        end
                    end
                end
                KIND_TICK: begin
                    if (phase_reg == PH_WAIT) begin
                        if (wait_timer_reg <= 16'd1) begin
                            wait_timer_next = 16'd0;
                            phase_next      = PH_ERR;
                            cause_next      = CAUSE_TIMEOUT;
                        end else begin
                            wait_timer_next = wait_timer_reg - 16'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (cfg_go && phase_reg == PH_IDLE) begin
            if (cfg_index == CFG_PACKET_COUNT) begin
                packets_left_next = COUNT_WIDTH'(cfg_data[15:0]);
            end
            if (cfg_index == CFG_START_SEED) begin
                packet_seed_next = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end else if (cfg_go) begin
            if (cfg_index == CFG_TIMEOUT_TICKS) begin
                timeout_ticks_reg <= cfg_data[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            cause_reg         <= CAUSE_NONE;
            packets_left_reg  <= COUNT_WIDTH'(PACKET_COUNT_RST);
            packet_seed_reg   <= START_SEED_RST;
            tx_lfsr_reg       <= 32'd0;
            tx_words_left_reg <= 8'd0;
            rx_lfsr_reg       <= 32'd0;
            rx_words_seen_reg <= 8'd0;
            wait_timer_reg    <= 16'd0;
        end else begin
            phase_reg         <= phase_next;
            cause_reg         <= cause_next;
            packets_left_reg  <= packets_left_next;
            packet_seed_reg   <= packet_seed_next;
            tx_lfsr_reg       <= tx_lfsr_next;
            tx_words_left_reg <= tx_words_left_next;
            rx_lfsr_reg       <= rx_lfsr_next;
            rx_words_seen_reg <= rx_words_seen_next;
            wait_timer_reg    <= wait_timer_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            m_phase_reg    <= phase_next;
            m_cause_reg    <= cause_next;
            m_tx_valid_reg <= m_tx_valid_next;
            m_tx_word_reg  <= m_tx_word_next;
            m_tx_last_reg  <= m_tx_last_next;
            m_tx_size_reg  <= m_tx_size_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_phase         = m_phase_reg;
    assign m_error_cause   = m_cause_reg;
    assign m_tx_valid      = m_tx_valid_reg;
    assign m_tx_word       = m_tx_word_reg;
    assign m_tx_last       = m_tx_last_reg;
    assign m_tx_size_bytes = m_tx_size_reg;

endmodule

`default_nettype wire

>>> rtl/core/prbs_echo_packet_tester_core.sv
// Results pass through a front-end queue entry and then the back-end output registers.
// Throughput: one item per cycle while m_ready is high; the back end updates state per item.
// A two-entry queue separates the classifying front end from the back end.
// Reset: aresetn synchronous, active low; config and state return to reset values at once.
`timescale 1ns / 1ps
`default_nettype none

module prbs_echo_packet_tester_core
    import pept_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic        s_tx_buffer_free,
    input  wire logic [31:0] s_rx_word,
    input  wire logic        s_rx_last,
    input  wire logic [10:0] s_rx_size_bytes,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_phase,
    output logic [2:0]       m_error_cause,
    output logic             m_tx_valid,
    output logic [31:0]      m_tx_word,
    output logic             m_tx_last,
    output logic [9:0]       m_tx_size_bytes
);

    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    pept_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_tx_buffer_free (s_tx_buffer_free),
        .s_rx_word        (s_rx_word),
        .s_rx_last        (s_rx_last),
        .s_rx_size_bytes  (s_rx_size_bytes),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_item           (q_item)
    );

    pept_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_item          (q_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_phase         (m_phase),
        .m_error_cause   (m_error_cause),
        .m_tx_valid      (m_tx_valid),
        .m_tx_word       (m_tx_word),
        .m_tx_last       (m_tx_last),
        .m_tx_size_bytes (m_tx_size_bytes)
    );

`ifndef SYNTH
    a_tx_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_tx_valid) |-> (m_phase == PH_SEND || m_phase == PH_WAIT))
        else $error("tx word outside send/wait");

    a_last_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_tx_valid && m_tx_last) |-> (m_phase == PH_WAIT))
        else $error("last tx word did not enter wait");

    a_cause_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error_cause != CAUSE_NONE) |-> (m_phase == PH_ERR))
        else $error("error cause without error phase");

    a_idle_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_tx_valid) |-> (m_tx_word == 32'd0 && m_tx_size_bytes == 10'd0))
        else $error("tx payload not cleared");
`endif

endmodule

`default_nettype wire

>>> tb/tb_prbs_echo_packet_tester_core.sv
`timescale 1ns / 1ps

module tb_prbs_echo_packet_tester_core;
    import pept_pkg::*;

    localparam int          ECHO_ITEMS  = 400;
    localparam logic [1:0]  CFG_UNUSED  = 2'd3;
    localparam logic [31:0] TAP_MASK    = 32'h8000_0053;

    typedef enum int {
        FAULT_NONE,
        FAULT_NO_BUF,
        FAULT_TIMEOUT,
        FAULT_DATA,
        FAULT_SIZE,
        FAULT_EARLY_LAST,
        FAULT_EXTRA_WORD
    } echo_fault_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [2:0]  cause;
        logic        tv;
        logic [31:0] word;
        logic        last;
        logic [9:0]  nbytes;
    } status_t;

    typedef struct packed {
        req_t        req;
        logic        bf;
        logic [31:0] word;
        logic        last;
        logic [10:0] nbytes;
        logic        pin;
        phase_t      ph;
    } probe_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_PACKET_COUNT;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    req_t        s_req_type = REQ_POLL;
    logic        s_tx_buffer_free = 1'b0;
    logic [31:0] s_rx_word = '0;
    logic        s_rx_last = 1'b0;
    logic [10:0] s_rx_size_bytes = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_phase;
    logic [2:0]  m_error_cause;
    logic        m_tx_valid;
    logic [31:0] m_tx_word;
    logic        m_tx_last;
    logic [9:0]  m_tx_size_bytes;

    // tester state as seen from outside
    phase_t      st_phase;
    cause_t      st_cause;
    logic [15:0] pk_left;
    logic [31:0] pk_seed;
    logic [31:0] gen_lfsr;
    logic [7:0]  gen_left;
    logic [31:0] chk_lfsr;
    logic [7:0]  chk_seen;
    logic [15:0] tick_left;
    logic [15:0] tmo_q;

    status_t status_due[$];
    status_t row_status = '0;
    logic    row_pinned = 1'b0;
    bit      quiet = 1'b0;
    int      mismatches = 0;

    probe_t probes [13] = '{
        '{REQ_PULL, 1'b0, 32'h0000_0000, 1'b0, 11'd0,    1'b1, PH_IDLE},
        '{REQ_PULL, 1'b1, 32'hFFFF_FFFF, 1'b1, 11'd2047, 1'b1, PH_IDLE},
        '{REQ_RX,   1'b0, 32'h0000_0000, 1'b0, 11'd0,    1'b1, PH_IDLE},
        '{REQ_RX,   1'b1, 32'hFFFF_FFFF, 1'b1, 11'd2047, 1'b1, PH_IDLE},
        '{REQ_RX,   1'b0, 32'h5A5A_5A5A, 1'b1, 11'd64,   1'b1, PH_IDLE},
        '{REQ_TICK, 1'b0, 32'h0000_0000, 1'b0, 11'd0,    1'b1, PH_IDLE},
        '{REQ_TICK, 1'b1, 32'hFFFF_FFFF, 1'b1, 11'd2047, 1'b1, PH_IDLE},
        '{REQ_POLL, 1'b1, 32'h0000_0000, 1'b0, 11'd0,    1'b1, PH_SEND},
        '{REQ_POLL, 1'b0, 32'hFFFF_FFFF, 1'b1, 11'd2047, 1'b1, PH_SEND},
        '{REQ_PULL, 1'b0, 32'h0000_0000, 1'b0, 11'd0,    1'b0, PH_SEND},
        '{REQ_RX,   1'b1, 32'hFFFF_FFFF, 1'b1, 11'd2047, 1'b1, PH_SEND},
        '{REQ_TICK, 1'b0, 32'h0000_0000, 1'b0, 11'd0,    1'b1, PH_SEND},
        '{REQ_PULL, 1'b1, 32'hFFFF_FFFF, 1'b1, 11'd2047, 1'b0, PH_SEND}
    };

    prbs_echo_packet_tester_core DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_tx_buffer_free(s_tx_buffer_free),
        .s_rx_word       (s_rx_word),
        .s_rx_last       (s_rx_last),
        .s_rx_size_bytes (s_rx_size_bytes),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_phase         (m_phase),
        .m_error_cause   (m_error_cause),
        .m_tx_valid      (m_tx_valid),
        .m_tx_word       (m_tx_word),
        .m_tx_last       (m_tx_last),
        .m_tx_size_bytes (m_tx_size_bytes)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("prbs_echo_packet_tester_core regression: fail");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready <= quiet || ($urandom_range(0, 99) >= 6);
    end

    function automatic logic [31:0] prbs_advance(input logic [31:0] s);
        return {^(s & TAP_MASK), s[31:1]};
    endfunction

    // payload bytes: count AND 0x3FC, at least 64
    function automatic logic [9:0] frame_bytes(input logic [15:0] left);
        return (left[9:6] == 4'd0) ? PAYLOAD_MIN_BYTES : {left[9:2], 2'b00};
    endfunction

    task automatic tester_fail(input cause_t c);
        st_phase = PH_ERR;
        st_cause = c;
    endtask

    task automatic apply_cfg(input logic [1:0] idx, input logic [31:0] val);
        case (idx)
            CFG_PACKET_COUNT: begin
                if (st_phase == PH_IDLE) pk_left = val[15:0];
            end
            CFG_START_SEED: begin
                if (st_phase == PH_IDLE) pk_seed = val;
            end
            CFG_TIMEOUT_TICKS: tmo_q = val[15:0];
            default: ;
        endcase
    endtask

    task automatic advance_tester(input req_t req, input logic bf, input logic [31:0] w,
                                  input logic lst, input logic [10:0] nb,
                                  output status_t r);
        logic [9:0] len;
        len = frame_bytes(pk_left);
        r = '0;
        case (req)
            REQ_POLL: begin
                if (st_phase == PH_IDLE || st_phase == PH_RECV) begin
                    if (pk_left == 16'd0) begin
                        st_phase = PH_OK;
                    end else if (!bf) begin
                        tester_fail(CAUSE_NO_BUF);
                    end else begin
                        gen_left = len[9:2];
                        gen_lfsr = pk_seed;
                        st_phase = PH_SEND;
                    end
                end
            end
            REQ_PULL: begin
                if (st_phase == PH_SEND && gen_left != 8'd0) begin
                    r.tv = 1'b1;
                    r.word = gen_lfsr;
                    r.last = (gen_left == 8'd1);
                    r.nbytes = len;
                    gen_lfsr = prbs_advance(gen_lfsr);
                    gen_left = gen_left - 8'd1;
                    if (gen_left == 8'd0) begin
                        st_phase = PH_WAIT;
                        tick_left = tmo_q;
                        chk_lfsr = pk_seed;
                        chk_seen = 8'd0;
                    end
                end
            end
            REQ_RX: begin
                if (st_phase == PH_WAIT && nb != 11'd0) begin
                    if (nb != {1'b0, len} || chk_seen >= len[9:2]) begin
                        tester_fail(CAUSE_SIZE);
                    end else if (w != chk_lfsr) begin
                        tester_fail(CAUSE_DATA);
                    end else begin
                        chk_lfsr = prbs_advance(chk_lfsr);
                        chk_seen = chk_seen + 8'd1;
                        if (lst) begin
                            if (chk_seen != len[9:2]) begin
                                tester_fail(CAUSE_SIZE);
                            end else begin
                                pk_left = pk_left - 16'd1;
                                pk_seed = chk_lfsr;
                                st_phase = PH_RECV;
                            end
                        end
                    end
                end
            end
            default: begin
                if (st_phase == PH_WAIT) begin
                    if (tick_left <= 16'd1) begin
                        tick_left = 16'd0;
                        tester_fail(CAUSE_TIMEOUT);
                    end else begin
                        tick_left = tick_left - 16'd1;
                    end
                end
            end
        endcase
        r.phase = st_phase;
        r.cause = st_cause;
    endtask

    always @(posedge aclk) begin : check_results
        status_t calc;
        status_t want;
        status_t got;
        if (!aresetn) begin
            st_phase = PH_IDLE;
            st_cause = CAUSE_NONE;
            pk_left = PACKET_COUNT_RST;
            pk_seed = START_SEED_RST;
            tmo_q = TIMEOUT_TICKS_RST;
            gen_lfsr = '0;
            gen_left = '0;
            chk_lfsr = '0;
            chk_seen = '0;
            tick_left = '0;
            status_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
            if (s_valid && s_ready) begin
                advance_tester(s_req_type, s_tx_buffer_free, s_rx_word, s_rx_last,
                               s_rx_size_bytes, calc);
                status_due.push_back(row_pinned ? row_status : calc);
            end
            if (m_valid && m_ready) begin
                got = {m_phase, m_error_cause, m_tx_valid, m_tx_word, m_tx_last,
                       m_tx_size_bytes};
                if (status_due.size() == 0) begin
                    $display("%0t unexpected transfer: phase=%0d cause=%0d", $time,
                             m_phase, m_error_cause);
                    mismatches++;
                end else begin
                    want = status_due.pop_front();
                    if (got !== want) begin
                        $display("%0t mismatch: exp ph=%0d ca=%0d tv=%0b w=%h l=%0b sz=%0d",
                                 $time, want.phase, want.cause, want.tv, want.word,
                                 want.last, want.nbytes);
                        $display("%0t           got ph=%0d ca=%0d tv=%0b w=%h l=%0b sz=%0d",
                                 $time, got.phase, got.cause, got.tv, got.word,
                                 got.last, got.nbytes);
                        mismatches++;
                    end
                end
            end
        end
    end

    task automatic send_item(input req_t req, input logic bf, input logic [31:0] w,
                             input logic lst, input logic [10:0] nb);
        while (!quiet && $urandom_range(0, 99) < 6) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_req_type = req;
        s_tx_buffer_free = bf;
        s_rx_word = w;
        s_rx_last = lst;
        s_rx_size_bytes = nb;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_random(input req_t req);
        send_item(req, 1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
                  11'($urandom_range(0, 2047)));
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic settle();
        s_valid = 1'b0;
        while (status_due.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // items that leave the phase unchanged
    task automatic noise_item();
        case ($urandom_range(0, 3))
            0: send_random(REQ_POLL);
            1: send_random(st_phase == PH_WAIT ? REQ_PULL : REQ_TICK);
            2: begin
                if (st_phase == PH_WAIT)
                    send_item(REQ_RX, 1'($urandom_range(0, 1)), $urandom,
                              1'($urandom_range(0, 1)), 11'd0);
                else
                    send_random(REQ_RX);
            end
            default: send_random((st_phase != PH_WAIT || tick_left > 16'd1) ?
                                 REQ_TICK : REQ_POLL);
        endcase
    endtask

    task automatic drain_tx(input bit noisy);
        while (st_phase == PH_SEND) begin
            if (noisy && $urandom_range(0, 9) == 0) noise_item();
            send_random(REQ_PULL);
        end
    endtask

    task automatic echo_back(input bit noisy, input echo_fault_t fault, input int bad_at);
        logic [9:0]  len;
        logic [31:0] w;
        logic        lst;
        logic [10:0] nb;
        int          nw;
        int          i;
        len = frame_bytes(pk_left);
        nw = int'(len[9:2]);
        i = 0;
        while (st_phase == PH_WAIT) begin
            if (noisy && $urandom_range(0, 9) == 0) noise_item();
            w = chk_lfsr;
            lst = (i == nw - 1) && (fault != FAULT_EXTRA_WORD);
            nb = {1'b0, len};
            if (i == bad_at) begin
                case (fault)
                    FAULT_DATA: w = w ^ (32'h1 << $urandom_range(0, 31));
                    FAULT_SIZE: begin
                        nb = 11'($urandom_range(1, 2047));
                        if (nb == {1'b0, len}) nb = nb ^ 11'h400;
                    end
                    FAULT_EARLY_LAST: lst = 1'b1;
                    default: ;
                endcase
            end
            send_item(REQ_RX, 1'($urandom_range(0, 1)), w, lst, nb);
            i++;
        end
    endtask

    initial begin : stimulus
        int          pkt;
        int          work;
        int          nw;
        int          bad_at;
        bit          noisy;
        logic [9:0]  len;
        echo_fault_t fault;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        cfg_write(CFG_PACKET_COUNT, 32'd0);
        cfg_write(CFG_PACKET_COUNT, 32'd65535);
        cfg_write(CFG_PACKET_COUNT, ($urandom_range(0, 3) == 0) ? $urandom_range(11, 13) :
                                                                 $urandom_range(60, 76));
        cfg_write(CFG_START_SEED, 32'hFFFF_FFFF);
        cfg_write(CFG_START_SEED, 32'h0000_0000);
        cfg_write(CFG_START_SEED, $urandom);
        cfg_write(CFG_TIMEOUT_TICKS, 32'd1);
        cfg_write(CFG_TIMEOUT_TICKS, 32'd65535);
        cfg_write(CFG_TIMEOUT_TICKS, $urandom_range(500, 65535));
        cfg_write(CFG_UNUSED, $urandom);

        foreach (probes[k]) begin
            row_pinned = probes[k].pin;
            row_status = '0;
            row_status.phase = probes[k].ph;
            row_status.cause = CAUSE_NONE;
            send_item(probes[k].req, probes[k].bf, probes[k].word, probes[k].last,
                      probes[k].nbytes);
        end
        row_pinned = 1'b0;

        pkt = 0;
        work = $size(probes);
        while (work < ECHO_ITEMS && pk_left != 16'd0) begin
            quiet = (pkt >= 4 && pkt < 7);
            noisy = ($urandom_range(0, 3) != 0);
            len = frame_bytes(pk_left);
            work += 1 + 2 * int'(len[9:2]);
            if (pkt != 0) begin
                if (pkt % 3 == 2) begin
                    settle();
                    case ($urandom_range(0, 2))
                        0: cfg_write(CFG_PACKET_COUNT, $urandom_range(0, 65535));
                        1: cfg_write(CFG_START_SEED, $urandom);
                        default: cfg_write(CFG_TIMEOUT_TICKS, $urandom_range(1, 65535));
                    endcase
                end
                send_item(REQ_POLL, 1'b1, $urandom, 1'($urandom_range(0, 1)),
                          11'($urandom_range(0, 2047)));
            end
            drain_tx(noisy);
            echo_back(noisy, FAULT_NONE, -1);
            pkt++;
        end
        quiet = 1'b0;

        // one terminal outcome per run; ok and error hold until reset
        settle();
        len = frame_bytes(pk_left);
        nw = int'(len[9:2]);
        fault = (pk_left == 16'd0) ? FAULT_NONE :
                echo_fault_t'($urandom_range(int'(FAULT_NO_BUF), int'(FAULT_EXTRA_WORD)));
        bad_at = (fault == FAULT_EARLY_LAST) ? $urandom_range(0, nw - 2) :
                 (fault == FAULT_EXTRA_WORD) ? -1 : $urandom_range(0, nw - 1);
        case (fault)
            FAULT_NONE: send_random(REQ_POLL);
            FAULT_NO_BUF: send_item(REQ_POLL, 1'b0, $urandom, 1'b0, 11'd0);
            FAULT_TIMEOUT: begin
                cfg_write(CFG_TIMEOUT_TICKS, $urandom_range(1, 4));
                send_item(REQ_POLL, 1'b1, 32'd0, 1'b0, 11'd0);
                drain_tx(1'b0);
                while (st_phase == PH_WAIT) send_random(REQ_TICK);
            end
            default: begin
                send_item(REQ_POLL, 1'b1, 32'd0, 1'b0, 11'd0);
                drain_tx(1'b1);
                echo_back(1'b1, fault, bad_at);
            end
        endcase

        repeat (20) send_random(req_t'($urandom_range(0, 3)));

        s_valid = 1'b0;
        while (status_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("prbs_echo_packet_tester_core regression: pass");
        else
            $display("prbs_echo_packet_tester_core regression: fail");
        $finish;
    end

endmodule

>>> prbs_echo_packet_tester_core.f
rtl/core/pept_pkg.sv
rtl/core/pept_front.sv
rtl/core/pept_back.sv
rtl/core/prbs_echo_packet_tester_core.sv
tb/tb_prbs_echo_packet_tester_core.sv
